// ===== design/seven_segment_scan_with_keys_unit_assert.svh =====
// Assertion macros shared by the display scan design.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SEVEN_SEGMENT_SCAN_WITH_KEYS_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_WITH_KEYS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition must hold at every clock edge.
`define SSK_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("display scan check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SSK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("display scan check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("display scan check failed");

`else

`define SSK_ASSERT_ALWAYS(label, prop)
`define SSK_ASSERT_IMP(label, ante, cons)
`define SSK_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/ssk_pkg.sv =====
package ssk_pkg;

    // Fixed sizes of the display and the scan counter.
    localparam int POSITIONS   = 6;
    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_W      = 3;
    localparam int STEP_W      = 5;
    localparam int SEG_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int KEY_COUNT   = 4;

    // Scan step at which the stored pattern is put on the lines.
    localparam logic [STEP_W-1:0] DRIVE_STEP = 5'd1;

    // Digit positions whose samples carry each key.
    localparam logic [SLOT_W-1:0] KEY_EXIT_DIGIT  = 3'd4;
    localparam logic [SLOT_W-1:0] KEY_LEFT_DIGIT  = 3'd2;
    localparam logic [SLOT_W-1:0] KEY_UP_DIGIT    = 3'd5;
    localparam logic [SLOT_W-1:0] KEY_ENTER_DIGIT = 3'd3;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // ASCII codes with a fixed meaning.
    localparam logic [CHAR_W-1:0] ASCII_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

    // Glyph table: letters first, then equals and dash, then the digits.
    localparam int GLYPH_COUNT = 38;
    localparam int GLYPH_IDX_W = 6;
    localparam logic [GLYPH_IDX_W-1:0] EQUALS_INDEX = 6'd26;
    localparam logic [GLYPH_IDX_W-1:0] DASH_INDEX   = 6'd27;
    localparam logic [GLYPH_IDX_W-1:0] DIGIT_BASE   = 6'd28;

    localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h0E,
        7'h00, 7'h38, 7'h00, 7'h54, 7'h3F, 7'h73, 7'h4F, 7'h50, 7'h6D, 7'h78,
        7'h1C, 7'h00, 7'h00, 7'h00, 7'h6E, 7'h5B,
        7'h48, 7'h40,
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // One input beat.
    typedef struct packed {
        logic                              command;
        logic                              key_level;
        logic [POSITIONS-1:0][CHAR_W-1:0]  chars;
        logic [POSITIONS-1:0]              point_mask;
    } item_t;

endpackage

// ===== design/ssk_glyph.sv =====
// Maps one ASCII character to its segment pattern; unknown codes are blank.
module ssk_glyph
(
    input  logic [ssk_pkg::CHAR_W-1:0] code,
    output logic [ssk_pkg::SEG_W-1:0]  pattern
);

    logic [ssk_pkg::CHAR_W-1:0] offset;

    always_comb
    begin
        offset  = '0;
        pattern = '0;
        if (code == ssk_pkg::ASCII_DASH)
        begin
            pattern = ssk_pkg::GLYPH_TABLE[ssk_pkg::DASH_INDEX];
        end
        else if (code == ssk_pkg::ASCII_EQUALS)
        begin
            pattern = ssk_pkg::GLYPH_TABLE[ssk_pkg::EQUALS_INDEX];
        end
        else if (code inside {[ssk_pkg::ASCII_ZERO:ssk_pkg::ASCII_NINE]})
        begin
            offset  = code - ssk_pkg::ASCII_ZERO;
            pattern = ssk_pkg::GLYPH_TABLE[offset[ssk_pkg::GLYPH_IDX_W-1:0]
                                           + ssk_pkg::DIGIT_BASE];
        end
        else if (code inside {[ssk_pkg::ASCII_UPPER_A:ssk_pkg::ASCII_UPPER_Z]})
        begin
            offset  = code - ssk_pkg::ASCII_UPPER_A;
            pattern = ssk_pkg::GLYPH_TABLE[offset[ssk_pkg::GLYPH_IDX_W-1:0]];
        end
        else if (code inside {[ssk_pkg::ASCII_LOWER_A:ssk_pkg::ASCII_LOWER_Z]})
        begin
            // Lower case shares the upper case entries.
            offset  = code - ssk_pkg::ASCII_LOWER_A;
            pattern = ssk_pkg::GLYPH_TABLE[offset[ssk_pkg::GLYPH_IDX_W-1:0]];
        end
    end

endmodule

// ===== design/ssk_input_stage.sv =====
// Input register: holds one beat until the core takes it.
module ssk_input_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ssk_pkg::item_t  in_item,
    output logic            item_valid,
    output ssk_pkg::item_t  item,
    input  logic            item_taken
);

    logic           valid_reg;
    logic           valid_next;
    ssk_pkg::item_t item_reg;

    // The register is free when empty or when its beat leaves this cycle.
    assign in_ready   = !valid_reg || item_taken;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_taken);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/ssk_core.sv =====
`include "seven_segment_scan_with_keys_unit_assert.svh"

// Scan state, pattern store, key samples and the result register.
module ssk_core
#(
    parameter int DIGIT_COUNT        = 6,
    parameter int STEPS_PER_DIGIT    = 25,
    parameter int FIRST_SAMPLE_STEP  = 10,
    parameter int SECOND_SAMPLE_STEP = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  ssk_pkg::item_t                      item,
    output logic                                item_taken,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssk_pkg::SEG_W-1:0]           segment_lines,
    output logic                                point_line,
    output logic [ssk_pkg::POSITIONS-1:0]       digit_enables,
    output logic [ssk_pkg::KEY_COUNT-1:0]       key_presses
);

    localparam int SW = ssk_pkg::STEP_W;
    localparam int DW = ssk_pkg::SLOT_W;

    logic [ssk_pkg::SEG_W-1:0]      glyph_pat [ssk_pkg::POSITIONS];

    logic [ssk_pkg::SEG_W-1:0]      pattern_reg [ssk_pkg::SLOT_COUNT];
    logic [ssk_pkg::SEG_W-1:0]      pattern_next [ssk_pkg::SLOT_COUNT];
    logic [ssk_pkg::SLOT_COUNT-1:0] point_reg;
    logic [ssk_pkg::SLOT_COUNT-1:0] point_next;
    logic [ssk_pkg::SLOT_COUNT-1:0] older_reg;
    logic [ssk_pkg::SLOT_COUNT-1:0] older_next;
    logic [ssk_pkg::SLOT_COUNT-1:0] first_reg;
    logic [ssk_pkg::SLOT_COUNT-1:0] first_next;
    logic [ssk_pkg::SLOT_COUNT-1:0] second_reg;
    logic [ssk_pkg::SLOT_COUNT-1:0] second_next;
    logic [SW-1:0]                  step_reg;
    logic [SW-1:0]                  step_next;
    logic [DW-1:0]                  digit_reg;
    logic [DW-1:0]                  digit_next;
    logic [ssk_pkg::SEG_W-1:0]      segment_reg;
    logic [ssk_pkg::SEG_W-1:0]      segment_next;
    logic                           point_drive_reg;
    logic                           point_drive_next;
    logic [ssk_pkg::POSITIONS-1:0]  enable_reg;
    logic [ssk_pkg::POSITIONS-1:0]  enable_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic                           advance;
    logic [SW-1:0]                  step_inc;
    logic [DW:0]                    digit_inc;
    logic [ssk_pkg::SLOT_COUNT-1:0] digit_onehot;

    // Character decoders, one per position.
    for (genvar k = 0; k < ssk_pkg::POSITIONS; k++)
    begin : g_glyph
        ssk_glyph u_glyph
        (
            .code    (item.chars[k]),
            .pattern (glyph_pat[k])
        );
    end

    // A beat moves on when the result register is empty or being emptied.
    assign advance    = item_valid && (!out_valid_reg || out_ready);
    assign item_taken = advance;

    assign step_inc     = step_reg + SW'(1);
    assign digit_inc    = {1'b0, digit_reg} + (DW+1)'(1);
    assign digit_onehot = ssk_pkg::SLOT_COUNT'(1) << digit_reg;

    // State update for one beat.
    always_comb
    begin
        pattern_next     = pattern_reg;
        point_next       = point_reg;
        older_next       = older_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        step_next        = step_reg;
        digit_next       = digit_reg;
        segment_next     = segment_reg;
        point_drive_next = point_drive_reg;
        enable_next      = enable_reg;
        if (advance)
        begin
            if (item.command == ssk_pkg::CMD_LOAD)
            begin
                // Point mask bits are stored in reverse position order.
                for (int k = 0; k < ssk_pkg::POSITIONS; k++)
                begin
                    pattern_next[k] = glyph_pat[k];
                    point_next[ssk_pkg::POSITIONS-1-k] = item.point_mask[k];
                end
            end
            else
            begin
                step_next = step_inc;
                if (step_inc == ssk_pkg::DRIVE_STEP)
                begin
                    segment_next     = pattern_reg[digit_reg];
                    point_drive_next = point_reg[digit_reg];
                    enable_next      = digit_onehot[ssk_pkg::POSITIONS-1:0];
                end
                if (step_inc == SW'(FIRST_SAMPLE_STEP))
                begin
                    older_next[digit_reg] = first_reg[digit_reg];
                    first_next[digit_reg] = item.key_level;
                end
                if (step_inc == SW'(SECOND_SAMPLE_STEP))
                begin
                    second_next[digit_reg] = item.key_level;
                end
                // End of this digit's window: blank the enables and move on.
                if (step_inc >= SW'(STEPS_PER_DIGIT))
                begin
                    enable_next = '0;
                    step_next   = '0;
                    if (digit_inc >= (DW+1)'(DIGIT_COUNT))
                    begin
                        digit_next = '0;
                    end
                    else
                    begin
                        digit_next = digit_inc[DW-1:0];
                    end
                end
            end
        end
    end

    // Result register flag: set by a beat moving in, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ssk_pkg::SLOT_COUNT; k++)
            begin
                pattern_reg[k] <= '0;
            end
            point_reg       <= '0;
            older_reg       <= '0;
            first_reg       <= '1;
            second_reg      <= '1;
            step_reg        <= '0;
            digit_reg       <= '0;
            segment_reg     <= '0;
            point_drive_reg <= 1'b0;
            enable_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pattern_reg     <= pattern_next;
            point_reg       <= point_next;
            older_reg       <= older_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            step_reg        <= step_next;
            digit_reg       <= digit_next;
            segment_reg     <= segment_next;
            point_drive_reg <= point_drive_next;
            enable_reg      <= enable_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // The drive registers are the result; they hold while it waits.
    assign out_valid     = out_valid_reg;
    assign segment_lines = segment_reg;
    assign point_line    = point_drive_reg;
    assign digit_enables = enable_reg;

    // A press reads high, then low, then low on its digit.
    assign key_presses[0] = older_reg[ssk_pkg::KEY_EXIT_DIGIT] &
                            ~first_reg[ssk_pkg::KEY_EXIT_DIGIT] &
                            ~second_reg[ssk_pkg::KEY_EXIT_DIGIT];
    assign key_presses[1] = older_reg[ssk_pkg::KEY_LEFT_DIGIT] &
                            ~first_reg[ssk_pkg::KEY_LEFT_DIGIT] &
                            ~second_reg[ssk_pkg::KEY_LEFT_DIGIT];
    assign key_presses[2] = older_reg[ssk_pkg::KEY_UP_DIGIT] &
                            ~first_reg[ssk_pkg::KEY_UP_DIGIT] &
                            ~second_reg[ssk_pkg::KEY_UP_DIGIT];
    assign key_presses[3] = older_reg[ssk_pkg::KEY_ENTER_DIGIT] &
                            ~first_reg[ssk_pkg::KEY_ENTER_DIGIT] &
                            ~second_reg[ssk_pkg::KEY_ENTER_DIGIT];

    // Scan invariants.
    `SSK_ASSERT_ALWAYS(a_enable_onehot, $onehot0(enable_reg))
    `SSK_ASSERT_ALWAYS(a_step_range, step_reg < SW'(STEPS_PER_DIGIT))
    `SSK_ASSERT_ALWAYS(a_digit_range, (DW+1)'(digit_reg) < (DW+1)'(DIGIT_COUNT))
    `SSK_ASSERT_IMP(a_enable_in_window, enable_reg != '0, step_reg != '0)
    `SSK_ASSERT_NEXT(a_load_keeps_scan, advance && item.command == ssk_pkg::CMD_LOAD,
                     step_reg == $past(step_reg) && enable_reg == $past(enable_reg))
    `SSK_ASSERT_NEXT(a_result_after_take, advance, out_valid_reg)

endmodule

// ===== design/seven_segment_scan_with_keys_unit.sv =====
// Six-digit multiplexed seven-segment driver with a four-key scan on one
// shared return line. Each input beat is either a load (six ASCII characters
// and a point mask, decoded into the pattern store) or one scan tick; every
// beat returns exactly one result showing the segment, point and digit-enable
// lines and the key-press flags after that beat. The block takes one beat per
// clock cycle while out_ready is high: a beat is held in the input register,
// then passes through the single decode-and-update path into the scan state
// registers, which also serve as the result register and hold while out_ready
// is low.
module seven_segment_scan_with_keys_unit
#(
    parameter int DIGIT_COUNT        = 6,
    parameter int STEPS_PER_DIGIT    = 25,
    parameter int FIRST_SAMPLE_STEP  = 10,
    parameter int SECOND_SAMPLE_STEP = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic                              key_level,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_0,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_1,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_2,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_3,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_4,
    input  logic [ssk_pkg::CHAR_W-1:0]        char_5,
    input  logic [ssk_pkg::POSITIONS-1:0]     point_mask,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ssk_pkg::SEG_W-1:0]         segment_lines,
    output logic                              point_line,
    output logic [ssk_pkg::POSITIONS-1:0]     digit_enables,
    output logic [ssk_pkg::KEY_COUNT-1:0]     key_presses
);

    ssk_pkg::item_t in_item;
    ssk_pkg::item_t item;
    logic           item_valid;
    logic           item_taken;

    // Gather the input beat.
    always_comb
    begin
        in_item.command    = command;
        in_item.key_level  = key_level;
        in_item.chars[0]   = char_0;
        in_item.chars[1]   = char_1;
        in_item.chars[2]   = char_2;
        in_item.chars[3]   = char_3;
        in_item.chars[4]   = char_4;
        in_item.chars[5]   = char_5;
        in_item.point_mask = point_mask;
    end

    ssk_input_stage u_input_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_taken (item_taken)
    );

    ssk_core
    #(
        .DIGIT_COUNT        (DIGIT_COUNT),
        .STEPS_PER_DIGIT    (STEPS_PER_DIGIT),
        .FIRST_SAMPLE_STEP  (FIRST_SAMPLE_STEP),
        .SECOND_SAMPLE_STEP (SECOND_SAMPLE_STEP)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_taken    (item_taken),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segment_lines (segment_lines),
        .point_line    (point_line),
        .digit_enables (digit_enables),
        .key_presses   (key_presses)
    );

endmodule

// ===== verif/ssk_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the display scan unit, predicts the result of every
// accepted beat and compares each returned beat with the oldest prediction.
module ssk_checker
    import ssk_pkg::*;
#(
    parameter int STEPS_PER_DIGIT    = 25,
    parameter int FIRST_SAMPLE_STEP  = 10,
    parameter int SECOND_SAMPLE_STEP = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  command,
    input  logic                  key_level,
    input  logic [CHAR_W-1:0]     char_0,
    input  logic [CHAR_W-1:0]     char_1,
    input  logic [CHAR_W-1:0]     char_2,
    input  logic [CHAR_W-1:0]     char_3,
    input  logic [CHAR_W-1:0]     char_4,
    input  logic [CHAR_W-1:0]     char_5,
    input  logic [POSITIONS-1:0]  point_mask,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [SEG_W-1:0]      segment_lines,
    input  logic                  point_line,
    input  logic [POSITIONS-1:0]  digit_enables,
    input  logic [KEY_COUNT-1:0]  key_presses,
    output int                    mismatches,
    output int                    outstanding,
    output int                    loads_seen,
    output int                    lines_checked,
    output int                    flagged_lines
);

    // What the display and key lines show after one beat.
    typedef struct packed {
        logic [SEG_W-1:0]     segs;
        logic                 dot;
        logic [POSITIONS-1:0] enables;
        logic [KEY_COUNT-1:0] keys;
    } line_state_t;

    // Segment font: letters A..Z, then equals and dash, then digits 0..9.
    localparam logic [SEG_W-1:0] SEG_FONT [38] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h0E,
        7'h00, 7'h38, 7'h00, 7'h54, 7'h3F, 7'h73, 7'h4F, 7'h50, 7'h6D, 7'h78,
        7'h1C, 7'h00, 7'h00, 7'h00, 7'h6E, 7'h5B,
        7'h48, 7'h40,
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Predicted state of the scan.
    logic [SEG_W-1:0]  font_ram  [POSITIONS];
    logic              dot_ram   [POSITIONS];
    logic              prior_lvl [POSITIONS];
    logic              early_lvl [POSITIONS];
    logic              late_lvl  [POSITIONS];
    logic [STEP_W-1:0] scan_step;
    int                scan_digit;
    logic [SEG_W-1:0]  segs_now;
    logic              dot_now;
    logic [POSITIONS-1:0] enables_now;

    line_state_t lines_q [$];

    // Maps one ASCII code to its segment pattern; unknown codes are blank.
    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        if (code == ASCII_DASH)
            return SEG_FONT[27];
        if (code == ASCII_EQUALS)
            return SEG_FONT[26];
        if (code >= ASCII_ZERO && code <= ASCII_NINE)
            return SEG_FONT[28 + int'(code - ASCII_ZERO)];
        if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_Z)
            return SEG_FONT[int'(code - ASCII_UPPER_A)];
        if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z)
            return SEG_FONT[int'(code - ASCII_LOWER_A)];
        return '0;
    endfunction

    // A key reads pressed when its digit saw high, then low twice.
    function automatic logic held(input int d);
        return prior_lvl[d] & ~early_lvl[d] & ~late_lvl[d];
    endfunction

    function automatic line_state_t current_lines();
        line_state_t v;
        v.segs    = segs_now;
        v.dot     = dot_now;
        v.enables = enables_now;
        v.keys    = {held(int'(KEY_ENTER_DIGIT)), held(int'(KEY_UP_DIGIT)),
                     held(int'(KEY_LEFT_DIGIT)), held(int'(KEY_EXIT_DIGIT))};
        return v;
    endfunction

    task automatic clear_scan();
        for (int k = 0; k < POSITIONS; k++)
        begin
            font_ram[k]  = '0;
            dot_ram[k]   = 1'b0;
            prior_lvl[k] = 1'b0;
            early_lvl[k] = 1'b1;
            late_lvl[k]  = 1'b1;
        end
        scan_step   = '0;
        scan_digit  = 0;
        segs_now    = '0;
        dot_now     = 1'b0;
        enables_now = '0;
    endtask

    // Applies one input beat to the predicted state.
    task automatic apply_beat(input logic cmd, input logic lvl,
                              input logic [POSITIONS-1:0][CHAR_W-1:0] chars,
                              input logic [POSITIONS-1:0] mask);
        if (cmd == CMD_LOAD)
        begin
            for (int k = 0; k < POSITIONS; k++)
            begin
                font_ram[k] = glyph_of(chars[k]);
                dot_ram[POSITIONS - 1 - k] = mask[k];
            end
        end
        else
        begin
            scan_step = scan_step + 1'b1;
            if (scan_step == DRIVE_STEP)
            begin
                segs_now    = font_ram[scan_digit];
                dot_now     = dot_ram[scan_digit];
                enables_now = POSITIONS'(1) << scan_digit;
            end
            if (scan_step == STEP_W'(FIRST_SAMPLE_STEP))
            begin
                prior_lvl[scan_digit] = early_lvl[scan_digit];
                early_lvl[scan_digit] = lvl;
            end
            if (scan_step == STEP_W'(SECOND_SAMPLE_STEP))
                late_lvl[scan_digit] = lvl;
            if (scan_step >= STEP_W'(STEPS_PER_DIGIT))
            begin
                enables_now = '0;
                scan_step   = '0;
                scan_digit  = (scan_digit == POSITIONS - 1) ? 0 : scan_digit + 1;
            end
        end
    endtask

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        loads_seen    = 0;
        lines_checked = 0;
        flagged_lines = 0;
        clear_scan();
    end

    // Everything changes on the rising edge, so the falling edge sees the
    // values that the next rising edge will act on.
    always @(negedge clk)
    begin
        line_state_t want;
        line_state_t got;
        if (!rst_n)
        begin
            clear_scan();
            lines_q.delete();
        end
        else
        begin
            // Input beat first: a returned beat always belongs to an older one.
            if (in_valid && in_ready)
            begin
                apply_beat(command, key_level,
                           {char_5, char_4, char_3, char_2, char_1, char_0}, point_mask);
                lines_q.push_back(current_lines());
                if (command == CMD_LOAD)
                    loads_seen++;
            end
            if (out_valid && out_ready)
            begin
                got = {segment_lines, point_line, digit_enables, key_presses};
                lines_checked++;
                if (got.keys != '0)
                    flagged_lines++;
                if (lines_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected: expected nothing, actual %h",
                             $time, got);
                end
                else
                begin
                    want = lines_q.pop_front();
                    if (got.segs !== want.segs)
                    begin
                        mismatches++;
                        $display("%0t: segment_lines expected %h actual %h",
                                 $time, want.segs, got.segs);
                    end
                    if (got.dot !== want.dot)
                    begin
                        mismatches++;
                        $display("%0t: point_line expected %b actual %b",
                                 $time, want.dot, got.dot);
                    end
                    if (got.enables !== want.enables)
                    begin
                        mismatches++;
                        $display("%0t: digit_enables expected %b actual %b",
                                 $time, want.enables, got.enables);
                    end
                    if (got.keys !== want.keys)
                    begin
                        mismatches++;
                        $display("%0t: key_presses expected %b actual %b",
                                 $time, want.keys, got.keys);
                    end
                end
            end
            outstanding = lines_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ssk_pkg::*;

    localparam int RANDOM_BEATS = 1625;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic                 command    = CMD_TICK;
    logic                 key_level  = 1'b0;
    logic [CHAR_W-1:0]    char_0     = '0;
    logic [CHAR_W-1:0]    char_1     = '0;
    logic [CHAR_W-1:0]    char_2     = '0;
    logic [CHAR_W-1:0]    char_3     = '0;
    logic [CHAR_W-1:0]    char_4     = '0;
    logic [CHAR_W-1:0]    char_5     = '0;
    logic [POSITIONS-1:0] point_mask = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b1;
    logic [SEG_W-1:0]     segment_lines;
    logic                 point_line;
    logic [POSITIONS-1:0] digit_enables;
    logic [KEY_COUNT-1:0] key_presses;

    int mismatches;
    int outstanding;
    int loads_seen;
    int lines_checked;
    int flagged_lines;

    // Shared between the sender and the receiver: 0 means no idling.
    int   idle_odds    = 0;
    logic hold_request = 1'b0;
    int   cycle_count  = 0;

    // Slowly changing key line so that press patterns actually form.
    logic key_now = 1'b0;
    int   key_run = 0;

    always #1 clk = ~clk;

    seven_segment_scan_with_keys_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key_level(key_level),
        .char_0(char_0), .char_1(char_1), .char_2(char_2),
        .char_3(char_3), .char_4(char_4), .char_5(char_5),
        .point_mask(point_mask),
        .out_valid(out_valid), .out_ready(out_ready),
        .segment_lines(segment_lines), .point_line(point_line),
        .digit_enables(digit_enables), .key_presses(key_presses)
    );

    ssk_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key_level(key_level),
        .char_0(char_0), .char_1(char_1), .char_2(char_2),
        .char_3(char_3), .char_4(char_4), .char_5(char_5),
        .point_mask(point_mask),
        .out_valid(out_valid), .out_ready(out_ready),
        .segment_lines(segment_lines), .point_line(point_line),
        .digit_enables(digit_enables), .key_presses(key_presses),
        .mismatches(mismatches), .outstanding(outstanding),
        .loads_seen(loads_seen), .lines_checked(lines_checked),
        .flagged_lines(flagged_lines)
    );

    // Offers one beat and returns just after the edge that accepts it.
    task automatic send_beat(input logic cmd, input logic lvl,
                             input logic [POSITIONS-1:0][CHAR_W-1:0] chars,
                             input logic [POSITIONS-1:0] mask);
        logic taken;
        command    <= cmd;
        key_level  <= lvl;
        char_0     <= chars[0];
        char_1     <= chars[1];
        char_2     <= chars[2];
        char_3     <= chars[3];
        char_4     <= chars[4];
        char_5     <= chars[5];
        point_mask <= mask;
        in_valid   <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Picks a character, weighted toward the ones the font knows.
    function automatic logic [CHAR_W-1:0] pick_char();
        logic [CHAR_W-1:0] edges [8] = '{8'h2F, 8'h3A, 8'h40, 8'h5B,
                                         8'h60, 8'h7B, 8'h7F, 8'hFF};
        logic [CHAR_W-1:0] plain [4] = '{8'h00, 8'h20, ASCII_DASH, ASCII_EQUALS};
        case ($urandom_range(0, 7))
            0: return ASCII_ZERO + CHAR_W'($urandom_range(0, 9));
            1: return ASCII_UPPER_A + CHAR_W'($urandom_range(0, 25));
            2: return ASCII_LOWER_A + CHAR_W'($urandom_range(0, 25));
            3: return plain[$urandom_range(0, 3)];
            4: return edges[$urandom_range(0, 7)];
            5: return CHAR_W'($urandom_range(0, 127));
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [POSITIONS-1:0][CHAR_W-1:0] pick_chars();
        logic [POSITIONS-1:0][CHAR_W-1:0] v;
        for (int k = 0; k < POSITIONS; k++)
            v[k] = pick_char();
        return v;
    endfunction

    // Receiver: random short stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                hold_request = 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sender: directed beats, then random traffic, then the verdict.
    initial
    begin
        logic                             lvl;
        logic [POSITIONS-1:0][CHAR_W-1:0] rnd_chars;
        int                               settle;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a tick from reset, then loads that cover blanks, dash,
        // equals, the ends of the digit and letter ranges, their neighbors
        // outside the font, and both extremes of the point mask.
        send_beat(CMD_TICK, 1'b0, '0, '0);
        send_beat(CMD_LOAD, 1'b1, {ASCII_NINE, ASCII_ZERO, ASCII_EQUALS, ASCII_DASH,
                                   8'h20, 8'h00}, 6'h3F);
        send_beat(CMD_LOAD, 1'b0, {8'h5B, 8'h40, ASCII_LOWER_Z, ASCII_LOWER_A,
                                   ASCII_UPPER_Z, ASCII_UPPER_A}, 6'h00);
        send_beat(CMD_LOAD, 1'b1, {8'h80, 8'hFF, 8'h3A, 8'h2F, 8'h7B, 8'h60}, 6'h15);
        send_beat(CMD_LOAD, 1'b0, {8'h37, 8'h38, 8'h50, 8'h6C, 8'h65, 8'h48}, 6'h2A);
        for (int k = 0; k < 20; k++)
            send_beat(CMD_TICK, 1'(k % 3 == 0), {6{8'hFF}}, 6'h3F);

        // Random part in segments of 100 beats with their own idle rate;
        // the last stretch runs without any idling.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 6;
                endcase
                if (n >= RANDOM_BEATS - 200)
                    idle_odds = 0;
            end
            if (n == 400)
                hold_request = 1'b1;
            if (n == 800)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end

            if (key_run == 0)
            begin
                key_now = 1'($urandom_range(0, 1));
                key_run = $urandom_range(20, 300);
            end
            key_run--;
            lvl = ($urandom_range(0, 15) == 0) ? 1'($urandom_range(0, 1)) : key_now;
            rnd_chars = pick_chars();

            if ($urandom_range(0, 11) == 0)
                send_beat(CMD_LOAD, lvl, rnd_chars, POSITIONS'($urandom_range(0, 63)));
            else
                send_beat(CMD_TICK, lvl, rnd_chars, POSITIONS'($urandom_range(0, 63)));

            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        // Drain, then keep clocking the idle block so that late misbehavior still shows.
        while (outstanding != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 10)
        begin
            @(posedge clk);
            settle++;
        end

        $display("tb: %0d loads and %0d result beats checked over full digit scans,",
                 loads_seen, lines_checked);
        $display("tb: %0d result beats carried a key press flag", flagged_lines);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ssk_pkg.sv
design/ssk_glyph.sv
design/ssk_input_stage.sv
design/ssk_core.sv
design/seven_segment_scan_with_keys_unit.sv
verif/ssk_checker.sv
verif/tb.sv
